>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif
`endif

>>> src/bedm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bedm_pkg
// Shared types, constants and helpers of the bounded edit-distance matcher.
// ----------------------------------------------------------------------------
package bedm_pkg;

  localparam int MAX_PATTERN_DEF = 64;
  localparam int MAX_NAME_DEF    = 512;

  localparam logic [2:0] DIST_SAT = 3'd4;

  typedef enum logic [1:0] {
    CMD_CLEAR   = 2'd0,
    CMD_PATTERN = 2'd1,
    CMD_NAME    = 2'd2,
    CMD_END     = 2'd3
  } cmd_t;

  // One slot of the systolic chain: a name character or an end-of-name token
  typedef struct packed {
    logic       vld;
    logic       fin;
    logic [7:0] ch;
    logic [2:0] up;
    logic [2:0] diag;
    logic       ok;
    logic [2:0] dval;
  } link_t;

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic       restart;
    logic       load;
    logic [7:0] ch;
    logic       icase;
    logic [1:0] thr;
  } cell_ctl_t;

  function automatic logic [7:0] swap_case(input logic [7:0] c);
    logic is_alpha;
    is_alpha = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    return is_alpha ? (c ^ 8'h20) : c;
  endfunction

endpackage

>>> src/bedm_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bedm_cell
// One pattern row of the edit-distance table: holds the pattern character,
// the row's current table entry and its within-threshold flag.
// ----------------------------------------------------------------------------
module bedm_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 7
) (
  input  logic              clk,
  input  logic              rst_n,
  input  bedm_pkg::cell_ctl_t ctl,
  input  logic [CNT_W-1:0]  pcount,
  input  bedm_pkg::link_t   link_in,
  output bedm_pkg::link_t   link_out
);
  import bedm_pkg::*;

  localparam logic [2:0] INIT = (IDX + 1 > 4) ? DIST_SAT : 3'(IDX + 1);

  logic [7:0] pchar_r, pchar_nxt;
  logic [2:0] dp_r, dp_nxt;
  logic       flag_r, flag_nxt;
  link_t      out_r, out_nxt;

  logic       same;
  logic       active;
  logic       last;
  logic [3:0] via_side;
  logic [3:0] via_diag;
  logic [3:0] best;
  logic [2:0] new_dp;

  always_comb begin
    active   = int'(pcount) > IDX;
    last     = int'(pcount) == IDX + 1;
    same     = (pchar_r == link_in.ch) || (ctl.icase && (swap_case(pchar_r) == link_in.ch));
    via_side = ((dp_r < link_in.up) ? {1'b0, dp_r} : {1'b0, link_in.up}) + 4'd1;
    via_diag = {1'b0, link_in.diag} + (same ? 4'd0 : 4'd1);
    best     = (via_diag < via_side) ? via_diag : via_side;
    new_dp   = (best > 4'd4) ? DIST_SAT : best[2:0];

    pchar_nxt = (ctl.load && (pcount == CNT_W'(IDX))) ? ctl.ch : pchar_r;
    dp_nxt    = dp_r;
    flag_nxt  = flag_r;
    out_nxt   = link_in;

    if (ctl.restart) begin
      dp_nxt   = INIT;
      flag_nxt = 1'b0;
    end else if (link_in.vld && !link_in.fin) begin
      dp_nxt       = new_dp;
      flag_nxt     = flag_r || (new_dp <= {1'b0, ctl.thr});
      out_nxt.up   = new_dp;
      out_nxt.diag = dp_r;
    end else if (link_in.vld && link_in.fin) begin
      // collect the row verdict, then restart the row for the next name
      out_nxt.ok   = link_in.ok && (flag_r || !active);
      out_nxt.dval = last ? dp_r : link_in.dval;
      dp_nxt       = INIT;
      flag_nxt     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    pchar_r <= pchar_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r   <= INIT;
      flag_r <= 1'b0;
      out_r  <= '0;
    end else begin
      dp_r   <= dp_nxt;
      flag_r <= flag_nxt;
      out_r  <= out_nxt;
    end
  end

  assign link_out = out_r;

endmodule

>>> src/bounded_edit_distance_match_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_edit_distance_match_top
// Levenshtein similarity check of a streamed name against a loaded pattern.
// ----------------------------------------------------------------------------
// Name characters are taken one per cycle while no end-of-name result is
// pending, and ripple through a chain of MAX_PATTERN cells, one per pattern
// row, each updating one table entry per cycle. Clear-pattern and
// pattern-character commands wait until the last name character has left the chain. End of
// name sends a token down the same chain that gathers the row verdicts and
// the final distance and restarts each row behind it; the result is
// registered as the token leaves the last cell, and no further input is
// taken until it has been transferred. The user must write the ignore_case
// register only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_edit_distance_match_top #(
  parameter int MAX_PATTERN = bedm_pkg::MAX_PATTERN_DEF,
  parameter int MAX_NAME    = bedm_pkg::MAX_NAME_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_command,
  input  logic [7:0] in_char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_similar,
  output logic [2:0] out_distance
);
  import bedm_pkg::*;

  localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
  localparam int NAME_W = $clog2(MAX_NAME + 1);
  localparam int DR_W   = $clog2(MAX_PATTERN + 1);
  localparam int SUM_W  = ((NAME_W > CNT_W) ? NAME_W : CNT_W) + 1;

  logic              icase_r;
  logic [CNT_W-1:0]  pcount_r, pcount_nxt;
  logic [NAME_W-1:0] name_cnt_r, name_cnt_nxt;
  logic [2:0]        dp0_r, dp0_nxt;
  logic [DR_W-1:0]   drain_r, drain_nxt;
  logic              busy_r, busy_nxt;
  link_t             inj_r, inj_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_similar_r, out_similar_nxt;
  logic [2:0]        out_distance_r, out_distance_nxt;

  cell_ctl_t         ctl;
  link_t             link_w [MAX_PATTERN+1];
  cmd_t              cmd;
  logic              xfer;
  logic              name_full;
  logic [1:0]        thr;
  logic [2:0]        up0;
  logic [SUM_W-1:0]  p_ext, n_ext, t_ext;
  logic              len_ok;
  link_t             tail;

  assign cmd  = cmd_t'(in_command);
  assign tail = link_w[MAX_PATTERN];

  always_comb begin
    if (int'(pcount_r) <= 1)       thr = 2'd0;
    else if (int'(pcount_r) <= 5)  thr = 2'd1;
    else if (int'(pcount_r) <= 10) thr = 2'd2;
    else                           thr = 2'd3;
  end

  assign name_full = int'(name_cnt_r) >= MAX_NAME;
  assign up0       = (int'(name_cnt_r) >= 3) ? DIST_SAT : 3'(name_cnt_r + 1'b1);
  assign p_ext     = SUM_W'(pcount_r);
  assign n_ext     = SUM_W'(name_cnt_r);
  assign t_ext     = SUM_W'(thr);
  assign len_ok    = (n_ext <= p_ext + t_ext) && (p_ext <= n_ext + t_ext);

  // name characters and end tokens may follow characters still in the chain; pattern edits may not
  assign in_ready = !busy_r &&
                    ((cmd == CMD_NAME) || (cmd == CMD_END) || (drain_r == '0));
  assign xfer     = in_valid && in_ready;

  always_comb begin
    pcount_nxt       = pcount_r;
    name_cnt_nxt     = name_cnt_r;
    dp0_nxt          = dp0_r;
    drain_nxt        = (drain_r != '0) ? drain_r - 1'b1 : drain_r;
    busy_nxt         = busy_r;
    inj_nxt          = '0;
    out_valid_nxt    = out_valid_r;
    out_similar_nxt  = out_similar_r;
    out_distance_nxt = out_distance_r;
    ctl.restart      = 1'b0;
    ctl.load         = 1'b0;
    ctl.ch           = in_char_code;
    ctl.icase        = icase_r;
    ctl.thr          = thr;

    if (xfer) begin
      unique case (cmd)
        CMD_CLEAR: begin
          pcount_nxt   = '0;
          ctl.restart  = 1'b1;
          name_cnt_nxt = '0;
          dp0_nxt      = 3'd0;
        end
        CMD_PATTERN: begin
          if (int'(pcount_r) < MAX_PATTERN) begin
            ctl.load   = 1'b1;
            pcount_nxt = pcount_r + 1'b1;
          end
          ctl.restart  = 1'b1;
          name_cnt_nxt = '0;
          dp0_nxt      = 3'd0;
        end
        CMD_NAME: begin
          // drop characters past the name limit
          if (!name_full) begin
            name_cnt_nxt = name_cnt_r + 1'b1;
            dp0_nxt      = up0;
            inj_nxt.vld  = 1'b1;
            inj_nxt.ch   = in_char_code;
            inj_nxt.up   = up0;
            inj_nxt.diag = dp0_r;
            drain_nxt    = DR_W'(MAX_PATTERN);
          end
        end
        CMD_END: begin
          inj_nxt.vld  = 1'b1;
          inj_nxt.fin  = 1'b1;
          inj_nxt.ok   = len_ok;
          inj_nxt.dval = dp0_r;
          busy_nxt     = 1'b1;
          name_cnt_nxt = '0;
          dp0_nxt      = 3'd0;
        end
        default: begin
        end
      endcase
    end

    if (tail.vld && tail.fin) begin
      out_valid_nxt    = 1'b1;
      out_similar_nxt  = tail.ok && (tail.dval <= {1'b0, thr});
      out_distance_nxt = tail.dval;
    end else if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
      busy_nxt      = 1'b0;
    end
  end

  assign link_w[0] = inj_r;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    bedm_cell #(
      .IDX   (k),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .pcount   (pcount_r),
      .link_in  (link_w[k]),
      .link_out (link_w[k+1])
    );
  end

  always_ff @(posedge clk) begin
    out_similar_r  <= out_similar_nxt;
    out_distance_r <= out_distance_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      icase_r     <= 1'b0;
      pcount_r    <= '0;
      name_cnt_r  <= '0;
      dp0_r       <= 3'd0;
      drain_r     <= '0;
      busy_r      <= 1'b0;
      inj_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        icase_r <= cfg_wdata;
      end
      pcount_r    <= pcount_nxt;
      name_cnt_r  <= name_cnt_nxt;
      dp0_r       <= dp0_nxt;
      drain_r     <= drain_nxt;
      busy_r      <= busy_nxt;
      inj_r       <= inj_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_similar  = out_similar_r;
  assign out_distance = out_distance_r;

  `ASSERT_CLK(a_out_while_busy, out_valid_r |-> busy_r, "result held without a pending end token")
  `ASSERT_CLK(a_tail_while_busy, (tail.vld && tail.fin) |-> (busy_r && !out_valid_r), "end token left the chain with no room")
  `ASSERT_NEVER(a_edit_while_draining, xfer && ((cmd == CMD_CLEAR) || (cmd == CMD_PATTERN)) && (drain_r != '0), "pattern edited while characters in flight")
  `ASSERT_CLK(a_dist_range, out_valid_r |-> (out_distance_r <= DIST_SAT), "distance above saturation")

endmodule

>>> test/tb_bounded_edit_distance_match_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_edit_distance_match_top
// Self-checking bench for the bounded edit-distance matcher.
// ----------------------------------------------------------------------------
// A short table of directed commands exercises the empty and one-character
// patterns, a pattern change during a name, a full pattern and an over-long
// name. Random bursts follow: patterns drawn mostly from a small alphabet,
// then names that are lightly edited copies of the pattern, with some noise.
// An in-bench row model tracks the pattern, table column and row flags; each
// verdict is checked in order against it, or for typed directed rows against
// the table. The case mode is toggled and sender and receiver gaps vary by phase.
// ----------------------------------------------------------------------------
module tb_bounded_edit_distance_match_top;
  import bedm_pkg::*;

  localparam int MAX_PAT      = MAX_PATTERN_DEF;
  localparam int MAX_NM       = MAX_NAME_DEF;
  localparam int DRAIN_CYCLES = MAX_PAT + 16;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_ITEMS = 880;
  localparam int NUM_PHASES   = 6;
  localparam int NUM_ROWS     = 24;

  typedef struct packed {
    logic       similar;
    logic [2:0] distance;
  } verdict_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] ch;
    logic [7:0] step;
    logic [9:0] reps;
    logic       typed;
    logic       sim;
    logic [2:0] dval;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       in_valid;
  logic       in_ready;
  logic [1:0] in_command;
  logic [7:0] in_char_code;
  logic       out_valid;
  logic       out_ready;
  logic       out_similar;
  logic [2:0] out_distance;

  // Row model of the matcher
  logic       icase_m;
  logic [7:0] pat_m [MAX_PAT];
  int         pat_len;
  int         name_len;
  logic [2:0] col_m [MAX_PAT + 1];
  logic       row_hit [MAX_PAT];

  verdict_t   verdict_q [$];
  int         failures;
  int         quiet_cycles;
  int         items_sent;
  int         send_idle_pct;
  int         recv_idle_pct;

  bounded_edit_distance_match_top dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_command   (in_command),
    .in_char_code (in_char_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_similar  (out_similar),
    .out_distance (out_distance)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [2:0] clip_dist(input int v);
    return (v > int'(DIST_SAT)) ? DIST_SAT : 3'(v);
  endfunction

  function automatic int row_budget(input int n);
    if (n <= 1) return 0;
    if (n <= 5) return 1;
    if (n <= 10) return 2;
    return 3;
  endfunction

  function automatic void restart_rows();
    for (int i = 0; i <= MAX_PAT; i++) col_m[i] = clip_dist(i);
    for (int i = 0; i < MAX_PAT; i++) row_hit[i] = 1'b0;
    name_len = 0;
  endfunction

  // Apply one command to the row model; produced is set on end of name
  task automatic advance_matcher(input cmd_t c, input logic [7:0] ch,
                                 output bit produced, output verdict_t v);
    int  budget, diff, best, diag, left, up;
    bit  same, ok;
    logic [7:0] p, p_swapped;
    produced = 1'b0;
    v        = '0;
    budget   = row_budget(pat_len);
    case (c)
      CMD_CLEAR: begin
        pat_len = 0;
        restart_rows();
      end
      CMD_PATTERN: begin
        if (pat_len < MAX_PAT) begin
          pat_m[pat_len] = ch;
          pat_len++;
        end
        restart_rows();
      end
      CMD_NAME: begin
        if (name_len < MAX_NM) begin
          name_len++;
          diag     = col_m[0];
          col_m[0] = clip_dist(name_len);
          for (int i = 1; i <= pat_len; i++) begin
            p = pat_m[i - 1];
            p_swapped = p;
            if (((p | 8'h20) >= 8'h61) && ((p | 8'h20) <= 8'h7A)) p_swapped = p ^ 8'h20;
            same = (p == ch) || (icase_m && (p_swapped == ch));
            left = col_m[i];
            up   = col_m[i - 1];
            best = left + 1;
            if (up + 1 < best) best = up + 1;
            if (diag + (same ? 0 : 1) < best) best = diag + (same ? 0 : 1);
            diag     = left;
            col_m[i] = clip_dist(best);
            if (col_m[i] <= budget) row_hit[i - 1] = 1'b1;
          end
        end
      end
      CMD_END: begin
        diff = (pat_len >= name_len) ? pat_len - name_len : name_len - pat_len;
        ok   = (diff <= budget) && (col_m[pat_len] <= budget);
        for (int i = 0; i < pat_len; i++)
          if (!row_hit[i]) ok = 1'b0;
        v.similar  = ok;
        v.distance = col_m[pat_len];
        produced   = 1'b1;
        restart_rows();
      end
    endcase
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 30) return 8'h61 + 8'($urandom_range(2));
    if (r < 60) return 8'h41 + 8'($urandom_range(2));
    if (r < 85) return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    return 8'($urandom_range(255));
  endfunction

  // Present one command and hold it until the transfer; valid stays high after
  task automatic send_item(input cmd_t c, input logic [7:0] ch,
                           input bit typed, input verdict_t typed_v);
    bit       took, produced;
    verdict_t v;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    in_valid     <= 1'b1;
    in_command   <= c;
    in_char_code <= ch;
    do begin
      @(negedge clk);
      took = in_ready;
      @(posedge clk);
    end while (!took);
    if (!((c == CMD_PATTERN && pat_len == MAX_PAT) || (c == CMD_NAME && name_len >= MAX_NM)))
      items_sent++;
    advance_matcher(c, ch, produced, v);
    if (produced) verdict_q.push_back(typed ? typed_v : v);
  endtask

  // Drop valid, wait for every verdict, then let the chain empty
  task automatic settle_block();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_icase(input logic value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    icase_m    = value;
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Check results and watch for a hang; sample between edges
  always @(negedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (out_valid && out_ready) begin
        if (verdict_q.size() == 0) begin
          $error("result with no verdict pending: similar=%0b distance=%0d",
                 out_similar, out_distance);
          failures++;
        end else begin
          want = verdict_q.pop_front();
          if (out_similar !== want.similar) begin
            $error("similar: expected %0b, got %0b", want.similar, out_similar);
            failures++;
          end
          if (out_distance !== want.distance) begin
            $error("distance: expected %0d, got %0d", want.distance, out_distance);
            failures++;
          end
        end
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    stim_row_t   directed_tbl [NUM_ROWS];
    stim_row_t   cur;
    logic [7:0]  name_q [$];
    int          roll, plen, nnames, edits, pos, phase_goal;
    logic [7:0]  c;

    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_valid      = 1'b0;
    in_command    = CMD_CLEAR;
    in_char_code  = 8'h00;
    out_ready     = 1'b0;
    failures      = 0;
    quiet_cycles  = 0;
    items_sent    = 0;
    send_idle_pct = 26;
    recv_idle_pct = 50;
    icase_m       = 1'b0;
    pat_len       = 0;
    restart_rows();

    directed_tbl = '{
      '{CMD_END,     8'hA5, 8'd0, 10'd1,   1'b1, 1'b1, 3'd0},  // empty vs empty
      '{CMD_NAME,    8'h00, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_NAME,    8'hFF, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_END,     8'h5A, 8'd0, 10'd1,   1'b1, 1'b0, 3'd2},
      '{CMD_PATTERN, 8'h41, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_END,     8'h00, 8'd0, 10'd1,   1'b1, 1'b0, 3'd1},  // empty name
      '{CMD_NAME,    8'h61, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_END,     8'hFF, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_NAME,    8'h41, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_END,     8'h3C, 8'd0, 10'd1,   1'b1, 1'b1, 3'd0},
      '{CMD_PATTERN, 8'h42, 8'd0, 10'd4,   1'b0, 1'b0, 3'd0},
      '{CMD_NAME,    8'h41, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_PATTERN, 8'h63, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},  // pattern grows mid-name
      '{CMD_NAME,    8'h41, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_NAME,    8'h62, 8'd0, 10'd4,   1'b0, 1'b0, 3'd0},
      '{CMD_NAME,    8'h43, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_END,     8'h81, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_CLEAR,   8'hFF, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_END,     8'h7E, 8'd0, 10'd1,   1'b1, 1'b1, 3'd0},
      '{CMD_PATTERN, 8'h20, 8'd3, 10'd70,  1'b0, 1'b0, 3'd0},  // overflows the store
      '{CMD_NAME,    8'h20, 8'd3, 10'd64,  1'b0, 1'b0, 3'd0},
      '{CMD_END,     8'h00, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0},
      '{CMD_NAME,    8'h7F, 8'd1, 10'd520, 1'b0, 1'b0, 3'd0},  // runs past the name limit
      '{CMD_END,     8'h55, 8'd0, 10'd1,   1'b0, 1'b0, 3'd0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    write_icase(1'b0);

    foreach (directed_tbl[r]) begin
      cur = directed_tbl[r];
      for (int k = 0; k < int'(cur.reps); k++)
        send_item(cur.cmd, cur.ch + 8'(k * cur.step), cur.typed,
                  verdict_t'{similar: cur.sim, distance: cur.dval});
    end

    items_sent = 0;
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      settle_block();
      send_idle_pct = (ph < 2) ? 26 : (ph < 4) ? 50 : 0;
      recv_idle_pct = (ph < 2) ? 50 : (ph < 4) ? 26 : 0;
      write_icase((ph % 2) == 0);
      phase_goal = (ph + 1) * RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < phase_goal) begin
        if ($urandom_range(99) < 20) begin
          send_item(CMD_CLEAR, 8'($urandom_range(255)), 1'b0, '0);
          roll = $urandom_range(99);
          plen = (roll < 10) ? $urandom_range(1) :
                 (roll < 85) ? $urandom_range(12, 2) :
                 (roll < 95) ? $urandom_range(30, 13) : $urandom_range(68, 60);
          repeat (plen) send_item(CMD_PATTERN, pick_char(), 1'b0, '0);
        end
        nnames = $urandom_range(4, 1);
        repeat (nnames) begin
          name_q.delete();
          if ($urandom_range(99) < 12) begin
            repeat ($urandom_range(15)) name_q.push_back(8'($urandom_range(255)));
          end else begin
            for (int k = 0; k < pat_len; k++) name_q.push_back(pat_m[k]);
            edits = $urandom_range($urandom_range(4));
            repeat (edits) begin
              pos = $urandom_range(name_q.size());
              case ($urandom_range(3))
                0: name_q.insert(pos, pick_char());
                1: if (pos < name_q.size()) name_q.delete(pos);
                2: if (pos < name_q.size()) name_q[pos] = pick_char();
                default: begin
                  if (pos < name_q.size()) begin
                    c = name_q[pos] | 8'h20;
                    if (c >= 8'h61 && c <= 8'h7A) name_q[pos] = name_q[pos] ^ 8'h20;
                  end
                end
              endcase
            end
          end
          foreach (name_q[k]) send_item(CMD_NAME, name_q[k], 1'b0, '0);
          // Mostly close the name; now and then break it off or let it run on
          roll = $urandom_range(99);
          if (roll < 4) send_item(CMD_PATTERN, pick_char(), 1'b0, '0);
          else if (roll >= 7) send_item(CMD_END, 8'($urandom_range(255)), 1'b0, '0);
        end
      end
    end

    settle_block();
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+src
src/bedm_pkg.sv
src/bedm_cell.sv
src/bounded_edit_distance_match_top.sv
test/tb_bounded_edit_distance_match_top.sv
